// ----- hw/rtl/teqtr_pkg.sv -----
// Shared constants, types and helper functions of the two-root trigonometric solver.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package teqtr_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int ANGLE_FRAC_BITS = 28;

    localparam int IN_W        = 32;
    localparam int OUT_W       = 31;
    localparam int SQRT_STEPS  = 32;
    localparam int RAD_W       = 64;
    localparam int REM_W       = 36;
    localparam int VEC_W       = 56;
    localparam int Z_W         = 64;
    localparam int BS_W        = 52;
    localparam int F_W         = 5;
    localparam int F_MAX       = 20;
    localparam int SHIFT_W     = 5;
    localparam int NORM_STAGES = 6;
    localparam int NORM_MSB    = 40;
    localparam int RND_SH      = 60 - ANGLE_FRAC_BITS;
    localparam int ANG_W       = Z_W - RND_SH;
    localparam int SUM_W       = ANG_W + 2;

    localparam logic signed [Z_W-1:0] PI_Q60 = 64'sh3243F6A8885A308D;
    localparam logic signed [Z_W-1:0] RND_HALF = 64'sd1 <<< (RND_SH - 1);
    localparam logic signed [ANG_W-1:0] PI_Q = ANG_W'((PI_Q60 + RND_HALF) >>> RND_SH);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SOLUTION = 2'd1,
        ST_DEGENERATE  = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic                     low_ratio;
        logic signed [IN_W-1:0]   cs;
        logic signed [IN_W-1:0]   cc;
        logic signed [BS_W-1:0]   bs;
    } side_t;

    typedef struct packed {
        side_t                    side;
        logic [RAD_W-1:0]         n;
        logic [REM_W-1:0]         rem;
        logic [SQRT_STEPS-1:0]    root;
    } sq_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic                     low_ratio;
    } tag_t;

    typedef struct packed {
        logic signed [VEC_W-1:0]  x;
        logic signed [VEC_W-1:0]  y;
        logic signed [Z_W-1:0]    z;
    } vec_t;

    typedef struct packed {
        tag_t                     tag;
        vec_t                     va;
        vec_t                     vp;
    } cstage_t;

    // Restoring long division, evaluated only while the angle table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q.60: pi/4 for i = 0, else from the truncated Taylor series.
    function automatic logic signed [Z_W-1:0] atan_q60(int i);
        logic signed [Z_W-1:0] acc;
        logic signed [Z_W-1:0] term;
        int e;
        acc = '0;
        if (i == 0) begin
            acc = PI_Q60 >>> 2;
        end
        else begin
            for (int k = 0; k < 31; k++) begin
                e = i * (2 * k + 1);
                if (e <= 60) begin
                    term = $signed(udiv64(64'd1 << (60 - e), 64'(2 * k + 1)));
                    acc  = (k % 2 == 1) ? acc - term : acc + term;
                end
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/teqtr_req_if.sv -----
// Request channel carrying the three equation coefficients.
// Depends on teqtr_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface teqtr_req_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [teqtr_pkg::IN_W-1:0]     coeff_sin;
    logic signed [teqtr_pkg::IN_W-1:0]     coeff_cos;
    logic signed [teqtr_pkg::IN_W-1:0]     rhs_value;

    modport source (output valid, output coeff_sin, output coeff_cos, output rhs_value,
                    input ready);
    modport sink   (input valid, input coeff_sin, input coeff_cos, input rhs_value,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/teqtr_rsp_if.sv -----
// Result channel carrying the two roots and the status code.
// Depends on teqtr_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface teqtr_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [teqtr_pkg::OUT_W-1:0]    theta_first;
    logic signed [teqtr_pkg::OUT_W-1:0]    theta_second;
    logic [1:0]                            status;

    modport source (output valid, output theta_first, output theta_second, output status,
                    input ready);
    modport sink   (input valid, input theta_first, input theta_second, input status,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/trig_equation_two_roots_unit.sv -----
// Solves coeff_sin*sin(t) + coeff_cos*cos(t) = rhs_value for its two roots, one request
// per clock cycle while the output register is not stalled. An accepted request passes through
// 4 front stages, 32 square root cells, 8 vector build, scaling and fold stages, CORDIC_STEPS CORDIC cells and
// 2 back stages; the latency is set by the length of this chain of cells. The whole chain
// advances together and holds while a finished result waits at the output register.
// Depends on teqtr_pkg, the two channel interfaces and the cell modules.
`timescale 1ns / 1ps
`default_nettype none

module trig_equation_two_roots_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    teqtr_req_if.sink         operands,
    teqtr_rsp_if.source       roots
);

    logic                 en;
    logic                 out_valid;
    teqtr_pkg::status_t   out_status;
    teqtr_pkg::sq_t       sq_chain [teqtr_pkg::SQRT_STEPS+1];
    teqtr_pkg::cstage_t   cd_chain [teqtr_pkg::CORDIC_STEPS+1];

    assign en = !out_valid || roots.ready;
    assign operands.ready = en;

    teqtr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (operands.valid),
        .coeff_sin (operands.coeff_sin),
        .coeff_cos (operands.coeff_cos),
        .rhs_value (operands.rhs_value),
        .head      (sq_chain[0])
    );

    for (genvar i = 0; i < teqtr_pkg::SQRT_STEPS; i++) begin : g_sqrt
        teqtr_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (sq_chain[i]),
            .next  (sq_chain[i+1])
        );
    end

    teqtr_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .root_in (sq_chain[teqtr_pkg::SQRT_STEPS]),
        .vec_out (cd_chain[0])
    );

    for (genvar i = 0; i < teqtr_pkg::CORDIC_STEPS; i++) begin : g_cordic
        teqtr_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .shift (teqtr_pkg::SHIFT_W'(i)),
            .angle (teqtr_pkg::atan_q60(i)),
            .prev  (cd_chain[i]),
            .next  (cd_chain[i+1])
        );
    end

    teqtr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .vec_in       (cd_chain[teqtr_pkg::CORDIC_STEPS]),
        .valid        (out_valid),
        .theta_first  (roots.theta_first),
        .theta_second (roots.theta_second),
        .status       (out_status)
    );

    assign roots.valid  = out_valid;
    assign roots.status = out_status;

    a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
        operands.ready == (!roots.valid || roots.ready))
        else $error("request ready does not follow the output register");

    a_fail_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (roots.valid && roots.status != teqtr_pkg::ST_OK)
        |-> (roots.theta_first == '0 && roots.theta_second == '0))
        else $error("roots not cleared on a failing status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid |-> (roots.status == teqtr_pkg::ST_OK
                         || roots.status == teqtr_pkg::ST_NO_SOLUTION
                         || roots.status == teqtr_pkg::ST_DEGENERATE))
        else $error("undefined status code on the result channel");

    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (roots.valid && !roots.ready) |=> $stable(cd_chain[teqtr_pkg::CORDIC_STEPS]))
        else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/teqtr_front.sv -----
// Front end: squares, range and branch tests, radicand scaling ahead of the root chain.
// Depends on teqtr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teqtr_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 valid,
    input  wire logic signed [teqtr_pkg::IN_W-1:0]    coeff_sin,
    input  wire logic signed [teqtr_pkg::IN_W-1:0]    coeff_cos,
    input  wire logic signed [teqtr_pkg::IN_W-1:0]    rhs_value,
    output teqtr_pkg::sq_t                            head
);

    logic                                  v1_reg;
    logic signed [teqtr_pkg::IN_W-1:0]     cs1_reg, cc1_reg, rv1_reg;
    logic signed [63:0]                    pcs1_reg, pcc1_reg, prv1_reg;
    logic signed [63:0]                    pcs_next, pcc_next, prv_next;

    logic                                  v2_reg;
    teqtr_pkg::status_t                    st2_reg, st2_next;
    logic                                  sm2_reg, sm2_next;
    logic [63:0]                           d2_reg, d2_next;
    logic signed [teqtr_pkg::IN_W-1:0]     cs2_reg, cc2_reg, rv2_reg;
    logic [63:0]                           m2, r2;

    logic                                  v3_reg;
    teqtr_pkg::status_t                    st3_reg;
    logic                                  sm3_reg;
    logic [63:0]                           d3_reg;
    logic [teqtr_pkg::F_W-1:0]             f3_reg, f3_next;
    logic signed [teqtr_pkg::IN_W-1:0]     cs3_reg, cc3_reg, rv3_reg;

    teqtr_pkg::sq_t                        head_reg, head_next;

    assign pcs_next = 64'(coeff_sin) * 64'(coeff_sin);
    assign pcc_next = 64'(coeff_cos) * 64'(coeff_cos);
    assign prv_next = 64'(rhs_value) * 64'(rhs_value);

    always_comb
    begin
        m2 = $unsigned(pcs1_reg) + $unsigned(pcc1_reg);
        r2 = $unsigned(prv1_reg);
        d2_next = m2 - r2;
        sm2_next = ({7'd0, r2} * 71'd100) < ({7'd0, m2} * 71'd49);
        if (m2 == 64'd0) begin
            st2_next = teqtr_pkg::ST_DEGENERATE;
        end
        else if (r2 > m2) begin
            st2_next = teqtr_pkg::ST_NO_SOLUTION;
        end
        else begin
            st2_next = teqtr_pkg::ST_OK;
        end
    end

    always_comb
    begin
        f3_next = '0;
        for (int k = 0; k < teqtr_pkg::F_MAX; k++) begin
            if (d2_reg < (64'd1 << (62 - 2 * k))) begin
                f3_next = f3_next + teqtr_pkg::F_W'(1);
            end
        end
    end

    always_comb
    begin
        head_next = '0;
        head_next.side.valid     = v3_reg;
        head_next.side.status    = st3_reg;
        head_next.side.low_ratio = sm3_reg;
        head_next.side.cs        = cs3_reg;
        head_next.side.cc        = cc3_reg;
        head_next.side.bs        = teqtr_pkg::BS_W'(rv3_reg) <<< f3_reg;
        head_next.n              = d3_reg << {f3_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            head_reg <= '0;
        end
        else if (en) begin
            v1_reg   <= valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            cs1_reg  <= coeff_sin;
            cc1_reg  <= coeff_cos;
            rv1_reg  <= rhs_value;
            pcs1_reg <= pcs_next;
            pcc1_reg <= pcc_next;
            prv1_reg <= prv_next;
            st2_reg  <= st2_next;
            sm2_reg  <= sm2_next;
            d2_reg   <= d2_next;
            cs2_reg  <= cs1_reg;
            cc2_reg  <= cc1_reg;
            rv2_reg  <= rv1_reg;
            st3_reg  <= st2_reg;
            sm3_reg  <= sm2_reg;
            d3_reg   <= d2_reg;
            f3_reg   <= f3_next;
            cs3_reg  <= cs2_reg;
            cc3_reg  <= cc2_reg;
            rv3_reg  <= rv2_reg;
        end
    end

    assign head = head_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/teqtr_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit from two radicand bits.
// Depends on teqtr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teqtr_sqrt_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire teqtr_pkg::sq_t prev,
    output teqtr_pkg::sq_t     next
);

    teqtr_pkg::sq_t                   cell_reg, cell_next;
    logic [teqtr_pkg::REM_W-1:0]      rem_sh;
    logic [teqtr_pkg::REM_W-1:0]      trial;

    always_comb
    begin
        cell_next = prev;
        rem_sh = {prev.rem[teqtr_pkg::REM_W-3:0], prev.n[teqtr_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, prev.root, 2'b01};
        cell_next.n = prev.n << 2;
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {prev.root[teqtr_pkg::SQRT_STEPS-2:0], 1'b1};
        end
        else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {prev.root[teqtr_pkg::SQRT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cell_reg <= '0;
        end
        else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign next = cell_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/teqtr_norm.sv -----
// Builds the two CORDIC vectors, scales them up by powers of two and folds the left half plane.
// Depends on teqtr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teqtr_norm (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire teqtr_pkg::sq_t root_in,
    output teqtr_pkg::cstage_t  vec_out
);

    localparam int LAST = teqtr_pkg::NORM_STAGES + 1;

    teqtr_pkg::cstage_t  stg_reg [LAST+1];
    teqtr_pkg::cstage_t  build_next;

    function automatic teqtr_pkg::vec_t scale_step(teqtr_pkg::vec_t v, int s);
        logic [teqtr_pkg::VEC_W-1:0] ax;
        logic [teqtr_pkg::VEC_W-1:0] ay;
        logic [teqtr_pkg::VEC_W-1:0] m;
        teqtr_pkg::vec_t r;
        r  = v;
        ax = v.x[teqtr_pkg::VEC_W-1] ? $unsigned(-v.x) : $unsigned(v.x);
        ay = v.y[teqtr_pkg::VEC_W-1] ? $unsigned(-v.y) : $unsigned(v.y);
        m  = (ax > ay) ? ax : ay;
        if (m < (teqtr_pkg::VEC_W'(1) << (teqtr_pkg::NORM_MSB + 1 - s))) begin
            r.x = v.x <<< s;
            r.y = v.y <<< s;
        end
        return r;
    endfunction

    function automatic teqtr_pkg::vec_t half_plane(teqtr_pkg::vec_t v);
        teqtr_pkg::vec_t r;
        r = v;
        if (v.x < 0) begin
            r.z = (v.y >= 0) ? teqtr_pkg::PI_Q60 : -teqtr_pkg::PI_Q60;
            r.x = -v.x;
            r.y = -v.y;
        end
        return r;
    endfunction

    always_comb
    begin
        build_next = '0;
        build_next.tag.valid     = root_in.side.valid;
        build_next.tag.status    = root_in.side.status;
        build_next.tag.low_ratio = root_in.side.low_ratio;
        if (root_in.side.low_ratio) begin
            build_next.va.y = teqtr_pkg::VEC_W'(root_in.side.bs);
            build_next.va.x = teqtr_pkg::VEC_W'($signed({1'b0, root_in.root}));
            build_next.vp.y = teqtr_pkg::VEC_W'(root_in.side.cc);
            build_next.vp.x = teqtr_pkg::VEC_W'(root_in.side.cs);
        end
        else begin
            build_next.va.y = teqtr_pkg::VEC_W'($signed({1'b0, root_in.root}));
            build_next.va.x = teqtr_pkg::VEC_W'(root_in.side.bs);
            build_next.vp.y = -teqtr_pkg::VEC_W'(root_in.side.cs);
            build_next.vp.x = teqtr_pkg::VEC_W'(root_in.side.cc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                stg_reg[k] <= '0;
            end
        end
        else if (en) begin
            stg_reg[0] <= build_next;
            for (int k = 1; k <= teqtr_pkg::NORM_STAGES; k++) begin
                stg_reg[k].tag <= stg_reg[k-1].tag;
                stg_reg[k].va  <= scale_step(stg_reg[k-1].va,
                                             1 << (teqtr_pkg::NORM_STAGES - k));
                stg_reg[k].vp  <= scale_step(stg_reg[k-1].vp,
                                             1 << (teqtr_pkg::NORM_STAGES - k));
            end
            stg_reg[LAST].tag <= stg_reg[LAST-1].tag;
            stg_reg[LAST].va  <= half_plane(stg_reg[LAST-1].va);
            stg_reg[LAST].vp  <= half_plane(stg_reg[LAST-1].vp);
        end
    end

    assign vec_out = stg_reg[LAST];

endmodule

`default_nettype wire

// ----- hw/rtl/teqtr_cordic_cell.sv -----
// One CORDIC vectoring iteration applied to both angle vectors of an item.
// Depends on teqtr_pkg; the shift and the table angle are tied off per position.
`timescale 1ns / 1ps
`default_nettype none

module teqtr_cordic_cell (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic [teqtr_pkg::SHIFT_W-1:0]        shift,
    input  wire logic signed [teqtr_pkg::Z_W-1:0]     angle,
    input  wire teqtr_pkg::cstage_t                   prev,
    output teqtr_pkg::cstage_t                        next
);

    teqtr_pkg::cstage_t  cell_reg, cell_next;

    function automatic teqtr_pkg::vec_t rotate(teqtr_pkg::vec_t v,
                                               logic [teqtr_pkg::SHIFT_W-1:0] s,
                                               logic signed [teqtr_pkg::Z_W-1:0] t);
        logic signed [teqtr_pkg::VEC_W-1:0] dx;
        logic signed [teqtr_pkg::VEC_W-1:0] dy;
        teqtr_pkg::vec_t r;
        dx = v.x >>> s;
        dy = v.y >>> s;
        if (v.y < 0) begin
            r.x = v.x - dy;
            r.y = v.y + dx;
            r.z = v.z - t;
        end
        else begin
            r.x = v.x + dy;
            r.y = v.y - dx;
            r.z = v.z + t;
        end
        return r;
    endfunction

    always_comb
    begin
        cell_next.tag = prev.tag;
        cell_next.va  = rotate(prev.va, shift, angle);
        cell_next.vp  = rotate(prev.vp, shift, angle);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cell_reg <= '0;
        end
        else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign next = cell_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/teqtr_back.sv -----
// Back end: rounds both angles, forms the two roots, folds them into range, output register.
// Depends on teqtr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teqtr_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire teqtr_pkg::cstage_t                    vec_in,
    output logic                                       valid,
    output logic signed [teqtr_pkg::OUT_W-1:0]         theta_first,
    output logic signed [teqtr_pkg::OUT_W-1:0]         theta_second,
    output teqtr_pkg::status_t                         status
);

    localparam logic signed [teqtr_pkg::SUM_W-1:0] PI_S  = teqtr_pkg::SUM_W'(teqtr_pkg::PI_Q);
    localparam logic signed [teqtr_pkg::SUM_W-1:0] PI2_S = PI_S <<< 1;

    logic signed [teqtr_pkg::Z_W-1:0]     za_rnd, zp_rnd;
    logic signed [teqtr_pkg::SUM_W-1:0]   a_ext, p_ext;
    logic signed [teqtr_pkg::SUM_W-1:0]   t1_reg, t1_next, t2_reg, t2_next;
    teqtr_pkg::tag_t                      tag_reg;

    logic                                 valid_reg;
    logic signed [teqtr_pkg::OUT_W-1:0]   th1_reg, th1_next, th2_reg, th2_next;
    teqtr_pkg::status_t                   st_reg;

    function automatic logic signed [teqtr_pkg::SUM_W-1:0] fold(
        logic signed [teqtr_pkg::SUM_W-1:0] t);
        logic signed [teqtr_pkg::SUM_W-1:0] r;
        r = t;
        if (r > PI_S) begin
            r = r - PI2_S;
        end
        if (r < -PI_S) begin
            r = r + PI2_S;
        end
        if (r > PI_S) begin
            r = PI_S;
        end
        if (r < -PI_S) begin
            r = -PI_S;
        end
        return r;
    endfunction

    always_comb
    begin
        za_rnd = vec_in.va.z + teqtr_pkg::RND_HALF;
        zp_rnd = vec_in.vp.z + teqtr_pkg::RND_HALF;
        a_ext  = teqtr_pkg::SUM_W'($signed(za_rnd[teqtr_pkg::Z_W-1:teqtr_pkg::RND_SH]));
        p_ext  = teqtr_pkg::SUM_W'($signed(zp_rnd[teqtr_pkg::Z_W-1:teqtr_pkg::RND_SH]));
        t1_next = a_ext - p_ext;
        if (vec_in.tag.low_ratio) begin
            t2_next = PI_S - a_ext - p_ext;
        end
        else begin
            t2_next = -a_ext - p_ext;
        end
    end

    always_comb
    begin
        if (tag_reg.status == teqtr_pkg::ST_OK) begin
            th1_next = teqtr_pkg::OUT_W'(fold(t1_reg));
            th2_next = teqtr_pkg::OUT_W'(fold(t2_reg));
        end
        else begin
            th1_next = '0;
            th2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
            st_reg    <= teqtr_pkg::ST_OK;
        end
        else if (en) begin
            tag_reg   <= vec_in.tag;
            valid_reg <= tag_reg.valid;
            st_reg    <= tag_reg.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            th1_reg <= th1_next;
            th2_reg <= th2_next;
        end
    end

    assign valid        = valid_reg;
    assign theta_first  = th1_reg;
    assign theta_second = th2_reg;
    assign status       = st_reg;

endmodule

`default_nettype wire
